>>> rtl/dlm_pkg.sv
package dlm_pkg;

    // Limb arithmetic, base 100000
    localparam int LIMB_W            = 17;
    localparam int PROD_W            = 2 * LIMB_W;
    localparam int POS_W             = 4;
    localparam int INDEX_W           = 3;
    localparam int MODE_W            = 2;
    localparam int LEN_REG_W         = 4;
    localparam int CFG_IDX_W         = 2;
    localparam int MAX_LIMBS_DEFAULT = 8;

    localparam logic [LIMB_W-1:0] LIMB_BASE = LIMB_W'(100000);
    localparam logic [LIMB_W-1:0] LIMB_MAXV = LIMB_W'(99999);

    // Request kinds carried in tuser
    localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_B = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW,
        S_STEP_RD,
        S_STEP_GO,
        S_STEP_WAIT,
        S_ROW_END,
        S_EMIT_RD,
        S_EMIT_LOAD
    } dlm_state_t;

    typedef enum logic [1:0] {
        MAC_IDLE,
        MAC_MUL,
        MAC_DIV,
        MAC_DONE
    } mac_phase_t;

    typedef struct packed {
        logic              done;
        logic [LIMB_W-1:0] limb;
        logic [LIMB_W-1:0] carry;
    } mac_res_t;

endpackage

>>> rtl/dlm_ram.sv
module dlm_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/dlm_serial_mac.sv
module dlm_serial_mac
    import dlm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [LIMB_W-1:0] a,
    input  logic [LIMB_W-1:0] b,
    input  logic [LIMB_W:0]   addend,
    output mac_res_t          res
);

    localparam int CNT_W = $clog2(LIMB_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LIMB_W - 1);

    mac_phase_t        phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [LIMB_W-1:0] mplier_reg, mplier_next;

    logic [PROD_W-1:0] acc_sum;
    logic [LIMB_W:0]   trial;
    logic              ge;
    logic [LIMB_W:0]   trial_sub;

    // One multiplier bit per cycle, then one quotient bit per cycle.
    // In the divide phase acc holds {remainder, dividend low bits / quotient}.
    assign acc_sum   = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign trial     = acc_reg[PROD_W-1:LIMB_W-1];
    assign ge        = (trial >= {1'b0, LIMB_BASE});
    assign trial_sub = trial - {1'b0, LIMB_BASE};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MAC_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        unique case (phase_reg)
            MAC_IDLE:
            begin
                if (start)
                begin
                    acc_next    = PROD_W'(addend);
                    mcand_next  = PROD_W'(a);
                    mplier_next = b;
                    cnt_next    = '0;
                    phase_next  = MAC_MUL;
                end
            end
            MAC_MUL:
            begin
                acc_next    = acc_sum;
                mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[LIMB_W-1:1]};
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    phase_next = MAC_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            MAC_DIV:
            begin
                acc_next = {(ge ? trial_sub[LIMB_W-1:0] : trial[LIMB_W-1:0]),
                            acc_reg[LIMB_W-2:0], ge};
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    phase_next = MAC_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            MAC_DONE:
            begin
                phase_next = MAC_IDLE;
            end
            default:
            begin
                phase_next = MAC_IDLE;
            end
        endcase
    end

    assign res.done  = (phase_reg == MAC_DONE);
    assign res.limb  = acc_reg[PROD_W-1:LIMB_W];
    assign res.carry = acc_reg[LIMB_W-1:0];

endmodule

>>> rtl/decimal_limb_multiplier.sv
// Schoolbook multiplier for unsigned numbers held as base-100000 limbs.
//
// Input stream (s_*): tuser carries the request kind. Load requests write one
// limb of operand A or B at limb_index (0 is most significant); the limb is
// saturated to 99999 and an index of MAX_LIMBS or more is dropped. A start
// request multiplies the first len_a limbs of A by the first len_b limbs of B.
// Configuration channel (cfg_*): index 0 sets len_a, index 1 sets len_b; a
// length of 0 acts as 1, one above MAX_LIMBS acts as MAX_LIMBS.
// Output stream (m_*): len_a+len_b product limbs, least significant first,
// tlast on the final one.
// Load requests are taken back to back while the block is idle. A start
// request keeps s_tready low for the whole run: every limb product passes
// through one bit-serial unit that does a shift-and-add multiply and then a
// restoring division by 100000, and every emitted limb takes one product-store
// read and one output-register load.
// A stalled receiver holds the output register and the emission sequence; once
// the final limb sits in the output register the block takes new requests.
// Reset returns len_a and len_b to 1 and empties the output register; operand
// limbs hold garbage until loaded.
module decimal_limb_multiplier
    import dlm_pkg::*;
#(
    parameter int MAX_LIMBS = MAX_LIMBS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // limb_index[2:0], limb_value[19:3], zeros
    input  logic [MODE_W-1:0]    s_tuser,   // mode[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // product_limb[16:0], limb_position[20:17], zeros
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_REG_W-1:0] cfg_data
);

    localparam int IDX_W  = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
    localparam int PIDX_W = $clog2(2 * MAX_LIMBS);

    // Effective length minus one: zero acts as one, oversize clamps.
    function automatic logic [IDX_W-1:0] len_m1(input logic [LEN_REG_W-1:0] len);
        logic [IDX_W-1:0] r;
        if (len == '0)
        begin
            r = '0;
        end
        else if (int'(len) > MAX_LIMBS)
        begin
            r = IDX_W'(MAX_LIMBS - 1);
        end
        else
        begin
            r = IDX_W'(len - 1'b1);
        end
        return r;
    endfunction

    // Request fields
    logic [INDEX_W-1:0] limb_index;
    logic [LIMB_W-1:0]  limb_value;
    logic [LIMB_W-1:0]  limb_sat;
    logic               in_accept;
    logic               index_ok;

    assign limb_index = s_tdata[INDEX_W-1:0];
    assign limb_value = s_tdata[INDEX_W+LIMB_W-1:INDEX_W];
    assign limb_sat   = (limb_value > LIMB_MAXV) ? LIMB_MAXV : limb_value;
    assign in_accept  = s_tvalid && s_tready;
    assign index_ok   = (int'(limb_index) < MAX_LIMBS);

    // Length registers
    logic [LEN_REG_W-1:0] len_a_reg, len_b_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg <= LEN_REG_W'(1);
            len_b_reg <= LEN_REG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_LEN_A)
            begin
                len_a_reg <= cfg_data;
            end
            else if (cfg_index == CFG_LEN_B)
            begin
                len_b_reg <= cfg_data;
            end
        end
    end

    // Sequencer state
    dlm_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  la_m1_reg, la_m1_next;
    logic [IDX_W-1:0]  lb_m1_reg, lb_m1_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [PIDX_W-1:0] k_reg, k_next;
    logic [LIMB_W-1:0] carry_reg, carry_next;

    logic              out_valid_reg, out_valid_next;
    logic [LIMB_W-1:0] out_limb_reg, out_limb_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic              out_last_reg, out_last_next;
    logic              out_load;

    // Operand and product stores
    logic              a_we, b_we, p_we;
    logic [IDX_W-1:0]  a_raddr, b_raddr;
    logic [LIMB_W-1:0] a_rdata, b_rdata, p_rdata;
    logic [PIDX_W-1:0] p_waddr, p_raddr;
    logic [LIMB_W-1:0] p_wdata;
    logic [PIDX_W-1:0] step_pos, carry_pos, last_pos;

    logic              mac_start;
    logic [LIMB_W:0]   mac_addend;
    mac_res_t          mac_res;

    assign a_we = in_accept && (s_tuser == MODE_LOAD_A) && index_ok;
    assign b_we = in_accept && (s_tuser == MODE_LOAD_B) && index_ok;

    // Walk operands from the least significant end
    assign a_raddr   = la_m1_reg - i_reg;
    assign b_raddr   = lb_m1_reg - j_reg;
    assign step_pos  = PIDX_W'(i_reg) + PIDX_W'(j_reg);
    assign carry_pos = PIDX_W'(j_reg) + PIDX_W'(la_m1_reg) + PIDX_W'(1);
    assign last_pos  = PIDX_W'(la_m1_reg) + PIDX_W'(lb_m1_reg) + PIDX_W'(1);
    assign p_raddr   = ((state_reg == S_EMIT_RD) || (state_reg == S_EMIT_LOAD)) ? k_reg
                                                                               : step_pos;

    // The first row adds no stored limb, only the carry; later rows read only written limbs.
    assign mac_addend = ((j_reg == '0) ? '0 : {1'b0, p_rdata}) + {1'b0, carry_reg};

    dlm_ram #(
        .WIDTH (LIMB_W),
        .DEPTH (MAX_LIMBS)
    ) u_ram_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (IDX_W'(limb_index)),
        .wdata (limb_sat),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    dlm_ram #(
        .WIDTH (LIMB_W),
        .DEPTH (MAX_LIMBS)
    ) u_ram_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (IDX_W'(limb_index)),
        .wdata (limb_sat),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    dlm_ram #(
        .WIDTH (LIMB_W),
        .DEPTH (2 * MAX_LIMBS)
    ) u_ram_p (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    dlm_serial_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_start),
        .a      (a_rdata),
        .b      (b_rdata),
        .addend (mac_addend),
        .res    (mac_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        la_m1_reg    <= la_m1_next;
        lb_m1_reg    <= lb_m1_next;
        carry_reg    <= carry_next;
        out_limb_reg <= out_limb_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
    end

    assign out_load = (state_reg == S_EMIT_LOAD) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        la_m1_next     = la_m1_reg;
        lb_m1_next     = lb_m1_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        carry_next     = carry_reg;
        out_limb_next  = out_limb_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;
        mac_start      = 1'b0;
        p_we           = 1'b0;
        p_waddr        = step_pos;
        p_wdata        = mac_res.limb;

        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && (s_tuser == MODE_START))
                begin
                    la_m1_next = len_m1(len_a_reg);
                    lb_m1_next = len_m1(len_b_reg);
                    i_next     = '0;
                    j_next     = '0;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                // Let the B limb of this row settle
                i_next     = '0;
                carry_next = '0;
                state_next = S_STEP_RD;
            end
            S_STEP_RD:
            begin
                state_next = S_STEP_GO;
            end
            S_STEP_GO:
            begin
                mac_start  = 1'b1;
                state_next = S_STEP_WAIT;
            end
            S_STEP_WAIT:
            begin
                if (mac_res.done)
                begin
                    p_we       = 1'b1;
                    carry_next = mac_res.carry;
                    if (i_reg == la_m1_reg)
                    begin
                        state_next = S_ROW_END;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_STEP_RD;
                    end
                end
            end
            S_ROW_END:
            begin
                // Store the row carry as the next higher limb
                p_we    = 1'b1;
                p_waddr = carry_pos;
                p_wdata = carry_reg;
                if (j_reg == lb_m1_reg)
                begin
                    k_next     = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_ROW;
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LOAD;
            end
            S_EMIT_LOAD:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_limb_next  = p_rdata;
                    out_pos_next   = POS_W'(k_reg);
                    out_last_next  = (k_reg == last_pos);
                    if (k_reg == last_pos)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_pos_reg, out_limb_reg};
    assign m_tlast  = out_last_reg;

    // Product writes stay inside the limbs of the current run
    a_pwrite_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        p_we |-> (p_waddr <= last_pos))
        else $error("product write beyond the top limb of the run");

    // The multiply unit reports only while the sequencer waits for it
    a_mac_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        mac_res.done |-> (state_reg == S_STEP_WAIT))
        else $error("multiply result arrived outside the wait state");

    // Loading the final limb returns the block to accepting requests
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (k_reg == last_pos)) |=> (state_reg == S_IDLE) && m_tvalid && m_tlast)
        else $error("final product limb did not close the run");

endmodule

>>> tb/sv/dlm_product_checker.sv
module dlm_product_checker
    import dlm_pkg::*;
#(
    parameter int MAX_LIMBS = MAX_LIMBS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [23:0]          s_tdata,   // limb_index[2:0], limb_value[19:3], zeros
    input  logic [MODE_W-1:0]    s_tuser,   // mode[1:0]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [23:0]          m_tdata,   // product_limb[16:0], limb_position[20:17], zeros
    input  logic                 m_tlast,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_REG_W-1:0] cfg_data,
    output int                   mismatches,
    output int                   limbs_due,
    output int                   limbs_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [LIMB_W-1:0] limb;
        logic [POS_W-1:0]  position;
        logic              last;
    } product_limb_t;

    logic [LIMB_W-1:0]    operand_a [MAX_LIMBS];
    logic [LIMB_W-1:0]    operand_b [MAX_LIMBS];
    logic [LEN_REG_W-1:0] len_a_reg;
    logic [LEN_REG_W-1:0] len_b_reg;
    product_limb_t        product_limbs_due [$];
    product_limb_t        due_limb;
    product_limb_t        seen_limb;
    logic [INDEX_W-1:0]   load_index;
    logic [LIMB_W-1:0]    load_value;
    int                   error_count;
    int                   compared_count;

    function automatic int clamp_length(input logic [LEN_REG_W-1:0] n);
        if (n == 0)
            return 1;
        if (n > MAX_LIMBS)
            return MAX_LIMBS;
        return int'(n);
    endfunction

    // Schoolbook product, rows taken from the least significant limb of B upwards
    task automatic multiply_operands();
        int                na;
        int                nb;
        longint unsigned   partial;
        longint unsigned   carry;
        logic [LIMB_W-1:0] store [2*MAX_LIMBS];
        product_limb_t     entry;
        na = clamp_length(len_a_reg);
        nb = clamp_length(len_b_reg);
        foreach (store[k])
            store[k] = '0;
        for (int j = 0; j < nb; j++)
        begin
            carry = 0;
            for (int i = 0; i < na; i++)
            begin
                partial = longint'(operand_b[nb-1-j]) * longint'(operand_a[na-1-i])
                        + longint'(store[i+j]) + carry;
                store[i+j] = LIMB_W'(partial % LIMB_BASE);
                carry      = partial / LIMB_BASE;
            end
            store[j+na] = LIMB_W'(carry);
        end
        for (int i = 0; i < na + nb; i++)
        begin
            entry.limb     = store[i];
            entry.position = POS_W'(i);
            entry.last     = (i == na + nb - 1);
            product_limbs_due.push_back(entry);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg      = LEN_REG_W'(1);
            len_b_reg      = LEN_REG_W'(1);
            error_count    = 0;
            compared_count = 0;
            product_limbs_due.delete();
            mismatches    <= 0;
            limbs_due     <= 0;
            limbs_checked <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LEN_A)
                    len_a_reg = cfg_data;
                else if (cfg_index == CFG_LEN_B)
                    len_b_reg = cfg_data;
            end

            if (s_tvalid && s_tready)
            begin
                load_index = s_tdata[INDEX_W-1:0];
                load_value = s_tdata[INDEX_W +: LIMB_W];
                if (load_value > LIMB_MAXV)
                    load_value = LIMB_MAXV;
                case (s_tuser)
                    MODE_LOAD_A:
                        if (load_index < MAX_LIMBS)
                            operand_a[load_index] = load_value;
                    MODE_LOAD_B:
                        if (load_index < MAX_LIMBS)
                            operand_b[load_index] = load_value;
                    MODE_START:
                        multiply_operands();
                    default:
                        ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                seen_limb.limb     = m_tdata[LIMB_W-1:0];
                seen_limb.position = m_tdata[LIMB_W +: POS_W];
                seen_limb.last     = m_tlast;
                if (product_limbs_due.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: unexpected product limb %0d pos %0d last %b",
                                 $time, seen_limb.limb, seen_limb.position, seen_limb.last);
                end
                else
                begin
                    due_limb = product_limbs_due.pop_front();
                    compared_count++;
                    if (seen_limb.limb !== due_limb.limb
                        || seen_limb.position !== due_limb.position
                        || seen_limb.last !== due_limb.last)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: expected %0d pos %0d last %b, got %0d pos %0d last %b",
                                     $time, due_limb.limb, due_limb.position, due_limb.last,
                                     seen_limb.limb, seen_limb.position, seen_limb.last);
                    end
                end
            end

            mismatches    <= error_count;
            limbs_due     <= product_limbs_due.size();
            limbs_checked <= compared_count;
        end
    end

endmodule

>>> tb/sv/tb_decimal_limb_multiplier.sv
module tb_decimal_limb_multiplier;
    timeunit 1ns;
    timeprecision 1ps;

    import dlm_pkg::*;

    localparam int                MAX_LIMBS    = MAX_LIMBS_DEFAULT;
    // Request kind that the block drops without a result
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
    localparam int                PAD_W        = 24 - INDEX_W - LIMB_W;
    localparam int                RANDOM_ITEMS = 350;
    localparam int                PHASE_ITEMS  = 30;
    // Receiver hold-off long enough to back the block up into its input
    localparam int                LONG_HOLD    = 400;
    // Idle cycles after the last product limb before touching the registers
    localparam int                SETTLE       = 8;
    localparam int                TAIL         = 64;
    localparam int                PRESSURE_PHASE = 2;
    localparam int                PAUSE_PHASE    = 1;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata   = '0;   // limb_index[2:0], limb_value[19:3], zeros
    logic [MODE_W-1:0]    s_tuser   = MODE_LOAD_A;   // mode[1:0]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;   // product_limb[16:0], limb_position[20:17], zeros
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LEN_A;
    logic [LEN_REG_W-1:0] cfg_data  = '0;

    int                   mismatches;
    int                   limbs_due;
    int                   limbs_checked;

    // Stimulus-side bookkeeping
    int                   tx_idle_pct    = 0;
    int                   rx_stall_pct   = 0;
    logic                 long_hold_req  = 1'b0;
    bit                   long_hold_done = 1'b0;
    logic [LEN_REG_W-1:0] len_a_now      = LEN_REG_W'(1);
    logic [LEN_REG_W-1:0] len_b_now      = LEN_REG_W'(1);
    int                   requests_sent  = 0;
    int                   multiplies     = 0;
    int                   phases_run     = 0;

    decimal_limb_multiplier #(
        .MAX_LIMBS (MAX_LIMBS)
    ) i_dut (
        .*
    );

    // Watches all three channels, predicts every product limb and compares
    dlm_product_checker #(
        .MAX_LIMBS (MAX_LIMBS)
    ) i_checker (
        .*
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop, well beyond the slowest legal run
    initial
    begin
        #25ms;
        $display("FAIL");
        $finish;
    end

    // Receiver: random stalls at the phase's rate, and one long hold-off on request.
    // The hold-off is counted here so that the sender keeps offering meanwhile.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Length as the block honours it: zero acts as one, oversize clamps
    function automatic int effective_length(input logic [LEN_REG_W-1:0] n);
        if (n == 0)
            return 1;
        return (n > MAX_LIMBS) ? MAX_LIMBS : int'(n);
    endfunction

    // Mostly in-range limbs, with the edges and saturating values mixed in
    function automatic logic [LIMB_W-1:0] random_limb();
        case ($urandom_range(7))
            0:       return '0;
            1:       return LIMB_MAXV;
            2:       return LIMB_W'($urandom_range(2**LIMB_W - 1, int'(LIMB_MAXV) + 1));
            default: return LIMB_W'($urandom_range(int'(LIMB_MAXV)));
        endcase
    endfunction

    // Favour short operands; keep the zero, oversize and full-size settings in play
    function automatic logic [LEN_REG_W-1:0] random_length();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return LEN_REG_W'($urandom_range(14, MAX_LIMBS + 1));
            3:       return LEN_REG_W'(MAX_LIMBS);
            default: return LEN_REG_W'($urandom_range(3, 1));
        endcase
    endfunction

    // Offer one request and hold it until taken. Called on a rising edge;
    // returns on the edge that accepted it, leaving tvalid high.
    task automatic send_request(input logic [MODE_W-1:0]  kind,
                                input logic [INDEX_W-1:0] idx,
                                input logic [LIMB_W-1:0]  value);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{PAD_W{1'b0}}, value, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (kind == MODE_START)
            multiplies++;
        if (kind != MODE_UNUSED)
            requests_sent++;
    endtask

    // Drop the input and wait for every predicted product limb to come out
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (limbs_due != 0)
            @(posedge clk);
    endtask

    // Raise cfg_valid with one register write and hold until taken
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [LEN_REG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Registers change only with the block idle: drain, settle, then write both
    task automatic reconfigure(input logic [LEN_REG_W-1:0] new_len_a,
                               input logic [LEN_REG_W-1:0] new_len_b);
        wait_for_drain();
        repeat (SETTLE) @(posedge clk);
        write_register(CFG_LEN_A, new_len_a);
        write_register(CFG_LEN_B, new_len_b);
        cfg_valid <= 1'b0;
        len_a_now = new_len_a;
        len_b_now = new_len_b;
    endtask

    // One random phase: fresh lengths, one idling style, then a mix of
    // well-formed operand loads followed by a multiply, and odd requests.
    task automatic run_phase(input int phase_no);
        int served;
        int na;
        int nb;
        bit reversed;
        if (phase_no == PRESSURE_PHASE)
            reconfigure(LEN_REG_W'(1), LEN_REG_W'(2));
        else
            reconfigure(random_length(), random_length());

        case (phase_no % 4)
            0:
            begin
                tx_idle_pct = 0;
                rx_stall_pct <= 0;
            end
            1:
            begin
                tx_idle_pct = 45;
                rx_stall_pct <= 0;
            end
            2:
            begin
                tx_idle_pct = 0;
                rx_stall_pct <= 45;
            end
            default:
            begin
                tx_idle_pct = 11;
                rx_stall_pct <= 11;
            end
        endcase

        // Stall the receiver for a long stretch and start a short multiply at
        // once, so its result sits in the output register and the input backs up
        if (phase_no == PRESSURE_PHASE)
        begin
            long_hold_req <= 1'b1;
            send_request(MODE_START, '0, '0);
        end

        served = 0;
        while (served < PHASE_ITEMS)
        begin
            if ($urandom_range(99) < 70)
            begin
                na       = effective_length(len_a_now);
                nb       = effective_length(len_b_now);
                reversed = $urandom_range(1);
                for (int i = 0; i < na; i++)
                    send_request(MODE_LOAD_A, INDEX_W'(reversed ? na - 1 - i : i),
                                 random_limb());
                for (int i = 0; i < nb; i++)
                    send_request(MODE_LOAD_B, INDEX_W'(reversed ? nb - 1 - i : i),
                                 random_limb());
                // Data fields of a start carry nothing; fill them with noise
                send_request(MODE_START, INDEX_W'($urandom), LIMB_W'($urandom));
                served += na + nb + 1;
                // Pause the sender until all limbs are back, always in one phase
                if (phase_no == PAUSE_PHASE || $urandom_range(9) == 0)
                    wait_for_drain();
            end
            else
            begin
                case ($urandom_range(3))
                    0: send_request(MODE_LOAD_A, INDEX_W'($urandom), random_limb());
                    1: send_request(MODE_LOAD_B, INDEX_W'($urandom), random_limb());
                    2: send_request(MODE_UNUSED, INDEX_W'($urandom), LIMB_W'($urandom));
                    default: send_request(MODE_START, INDEX_W'($urandom), LIMB_W'($urandom));
                endcase
                if (s_tuser != MODE_UNUSED)
                    served++;
            end
        end
    endtask

    initial
    begin
        int directed_count;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full-size operands with every limb at its top value, the
        // saturating loads on the two most significant limbs of A and the least of B
        reconfigure(LEN_REG_W'(MAX_LIMBS), LEN_REG_W'(MAX_LIMBS));
        for (int i = 0; i < MAX_LIMBS; i++)
            send_request(MODE_LOAD_A, INDEX_W'(i),
                         (i == 0) ? '1 : ((i == 1) ? LIMB_BASE : LIMB_MAXV));
        for (int i = 0; i < MAX_LIMBS; i++)
            send_request(MODE_LOAD_B, INDEX_W'(i), (i == MAX_LIMBS - 1) ? '1 : LIMB_MAXV);
        // Unused mode with every data bit set must leave no trace
        send_request(MODE_UNUSED, '1, '1);
        send_request(MODE_START, '0, '0);

        // Zero in the top limb of A and the bottom limb of B
        send_request(MODE_LOAD_A, '0, '0);
        send_request(MODE_LOAD_B, INDEX_W'(MAX_LIMBS - 1), '0);
        send_request(MODE_START, '1, '1);

        // Length zero on one side, oversize on the other, then swapped
        reconfigure('0, '1);
        send_request(MODE_START, '0, '0);
        reconfigure('1, '0);
        send_request(MODE_START, '0, '0);

        // Smallest product, and a zero times a top limb
        reconfigure(LEN_REG_W'(1), LEN_REG_W'(1));
        send_request(MODE_START, '0, '0);
        send_request(MODE_LOAD_B, '0, LIMB_MAXV);
        send_request(MODE_START, '0, '0);

        // Just above the limit on A against two limbs of B
        reconfigure(LEN_REG_W'(MAX_LIMBS + 1), LEN_REG_W'(2));
        send_request(MODE_LOAD_A, '0, LIMB_W'(1));
        send_request(MODE_START, '0, '0);

        directed_count = requests_sent;

        // Random phases, cycling through the idling styles
        while (requests_sent - directed_count < RANDOM_ITEMS)
        begin
            run_phase(phases_run);
            phases_run++;
        end

        wait_for_drain();
        repeat (TAIL) @(posedge clk);

        $display("Run covered %0d requests with %0d multiplies over %0d random phases,",
                 requests_sent, multiplies, phases_run);
        $display("lengths from zero to oversize, %0d product limbs compared, %0d mismatches.",
                 limbs_checked, mismatches);
        if (mismatches == 0 && limbs_due == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
